@@ rtl/trwm_pkg.sv @@
// ----------------------------------------------------------------------------
// trwm_pkg
// Shared types, register map and constants of the text run width measure.
// ----------------------------------------------------------------------------
package trwm_pkg;

    // Default parameter values.
    localparam int GLYPH_ENTRIES_DEF = 256;
    localparam int SUM_BITS_DEF      = 24;

    // Configuration port geometry: eight registers at 4-byte strides.
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // Register indexes.
    localparam logic [2:0] REG_SPACING  = 3'd0;
    localparam logic [2:0] REG_FALLBACK = 3'd1;
    localparam logic [2:0] REG_EXTRA    = 3'd2;
    localparam logic [2:0] REG_SIMPLE   = 3'd3;
    localparam logic [2:0] REG_DEFADV   = 3'd4;
    localparam logic [2:0] REG_GCOUNT   = 3'd5;
    localparam logic [2:0] REG_SCALE    = 3'd6;
    localparam logic [2:0] REG_HLWIDE   = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_FALLBACK = 16'd8;
    localparam logic [15:0] RST_SCALE    = 16'd16384;

    // Special byte codes.
    localparam logic [7:0] BOM_FIRST  = 8'hFF;
    localparam logic [7:0] BOM_SECOND = 8'hFE;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_NUL   = 8'h00;

    // Input command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    // Width of the per-character increment: three 16-bit terms.
    localparam int INC_W = 18;

    typedef struct packed {
        logic [15:0] spacing;
        logic [15:0] fallback_advance;
        logic [15:0] extra_unknown_advance;
        logic        simple_mode;
        logic [7:0]  default_advance;
        logic [8:0]  glyph_count;
        logic [15:0] scale_factor;
        logic        headerless_wide;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] width;
        logic [7:0]  kerning;
    } t_glyph;

    // Step controls from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic calc_inc;
        logic accum;
        logic mult;
        logic clear;
    } t_dp_ctrl;

endpackage

@@ rtl/trwm_in_if.sv @@
// ----------------------------------------------------------------------------
// trwm_in_if
// Input channel: one word is either a glyph table load or one text byte.
// ----------------------------------------------------------------------------
interface trwm_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  text_byte;
    logic [7:0]  entry_index;
    logic [7:0]  entry_code;
    logic [15:0] entry_width;
    logic [7:0]  entry_kerning;

    modport source (
        output valid, cmd, text_byte, entry_index, entry_code, entry_width,
               entry_kerning,
        input  ready
    );

    modport sink (
        input  valid, cmd, text_byte, entry_index, entry_code, entry_width,
               entry_kerning,
        output ready
    );
endinterface

@@ rtl/trwm_out_if.sv @@
// ----------------------------------------------------------------------------
// trwm_out_if
// Result channel: one word per measured string.
// ----------------------------------------------------------------------------
interface trwm_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_total;
    logic [31:0] scaled_width;
    logic [15:0] char_count;
    logic        wide_detected;
    logic        saturated;

    modport source (
        output valid, raw_total, scaled_width, char_count, wide_detected,
               saturated,
        input  ready
    );

    modport sink (
        input  valid, raw_total, scaled_width, char_count, wide_detected,
               saturated,
        output ready
    );
endinterface

@@ rtl/trwm_glyph_mem.sv @@
// ----------------------------------------------------------------------------
// trwm_glyph_mem
// Glyph table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module trwm_glyph_mem
    import trwm_pkg::*;
#(
    parameter int ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_glyph           i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_glyph           o_rdata
);

    t_glyph r_mem [ENTRIES];
    t_glyph r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/trwm_datapath.sv @@
// ----------------------------------------------------------------------------
// trwm_datapath
// Shared arithmetic: increment, saturating accumulate, count and final scale.
// ----------------------------------------------------------------------------
module trwm_datapath
    import trwm_pkg::*;
#(
    parameter int SUM_BITS = SUM_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_ctrl            i_ctrl,
    input  t_cfg                i_cfg,
    input  logic                i_found,
    input  t_glyph              i_glyph,
    output logic [SUM_BITS-1:0] o_sum,
    output logic [15:0]         o_count,
    output logic                o_clip,
    output logic [31:0]         o_scaled
);

    localparam int ADD_W  = ((SUM_BITS > INC_W) ? SUM_BITS : INC_W) + 1;
    localparam int PROD_W = SUM_BITS + 17;
    localparam logic signed [ADD_W-1:0] SUM_HI =
        ADD_W'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
    localparam logic signed [ADD_W-1:0] SUM_LO = -SUM_HI - ADD_W'(1);
    localparam logic signed [PROD_W-1:0] S32_HI = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] S32_LO = PROD_W'(-64'sd2147483648);

    logic signed [SUM_BITS-1:0] r_sum;
    logic        [15:0]         r_count;
    logic                       r_clip;
    logic signed [INC_W-1:0]    r_inc;
    logic signed [PROD_W-1:0]   r_prod;

    logic signed [INC_W-1:0]  w_inc;
    logic signed [ADD_W-1:0]  w_add;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_bias;
    logic signed [PROD_W-1:0] w_quot;

    always_comb begin
        w_inc = INC_W'($signed(i_cfg.spacing));
        if (!i_found) begin
            w_inc = w_inc + INC_W'($signed(i_cfg.fallback_advance))
                          + INC_W'($signed(i_cfg.extra_unknown_advance));
        end else if (i_cfg.simple_mode) begin
            w_inc = w_inc + INC_W'($signed(i_cfg.default_advance));
        end else begin
            w_inc = w_inc + INC_W'($signed(i_glyph.width))
                          + INC_W'($signed(i_glyph.kerning));
        end
    end

    assign w_add  = ADD_W'(r_sum) + ADD_W'(r_inc);
    assign w_prod = PROD_W'(r_sum) * PROD_W'($signed({1'b0, i_cfg.scale_factor}));

    // Divide by 64 with truncation toward zero, then clamp to 32 bits.
    assign w_bias = r_prod + (r_prod[PROD_W-1] ? PROD_W'(63) : PROD_W'(0));
    assign w_quot = w_bias >>> 6;

    always_comb begin
        if (w_quot > S32_HI) begin
            o_scaled = S32_HI[31:0];
        end else if (w_quot < S32_LO) begin
            o_scaled = S32_LO[31:0];
        end else begin
            o_scaled = w_quot[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_sum   <= '0;
            r_count <= '0;
            r_clip  <= 1'b0;
        end else if (i_ctrl.accum) begin
            if (w_add > SUM_HI) begin
                r_sum  <= SUM_HI[SUM_BITS-1:0];
                r_clip <= 1'b1;
            end else if (w_add < SUM_LO) begin
                r_sum  <= SUM_LO[SUM_BITS-1:0];
                r_clip <= 1'b1;
            end else begin
                r_sum <= w_add[SUM_BITS-1:0];
            end
            if (r_count == 16'hFFFF) begin
                r_clip <= 1'b1;
            end else begin
                r_count <= r_count + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc_inc) begin
            r_inc <= w_inc;
        end
        if (i_ctrl.mult) begin
            r_prod <= w_prod;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;
    assign o_clip  = r_clip;

endmodule

@@ rtl/text_run_width_measure.sv @@
// ----------------------------------------------------------------------------
// text_run_width_measure
// Measures the advance width of byte-wise text against a loaded glyph table.
// A text byte that completes a character scans up to N = min(glyph_count,
// GLYPH_ENTRIES) entries, one entry per cycle on the glyph memory read port,
// then forms and accumulates its increment; a terminator adds the multiply
// and result load steps, the latter waiting for a free result register. The
// input is not ready while a word is in progress. Reset clears string state
// and registers; the glyph table is not cleared and holds nothing until loaded.
// ----------------------------------------------------------------------------
module text_run_width_measure
    import trwm_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int SUM_BITS      = SUM_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    // Word channels.
    trwm_in_if.sink           i_in,
    trwm_out_if.source        o_out
);

    // Index width of the glyph memory and width of the scan counter, which
    // must hold the entry count itself as well as the 9-bit glyph_count.
    localparam int IDX_W = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int CNT_W = $clog2(GLYPH_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > 9) ? CNT_W : 9;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_INC    = 3'd2;
    localparam logic [2:0] S_ACC    = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    // String phases: start of string, leading 0xFF held while the mark is
    // undecided, walking, and walking with the low byte of a UTF-16 pair held.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_MARK  = 2'd1;
    localparam logic [1:0] PH_WALK  = 2'd2;
    localparam logic [1:0] PH_PAIR  = 2'd3;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase;
    // pready is tied high so every access finishes without wait states.
    // ------------------------------------------------------------------
    t_cfg r_cfg;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing               <= '0;
            r_cfg.fallback_advance      <= RST_FALLBACK;
            r_cfg.extra_unknown_advance <= '0;
            r_cfg.simple_mode           <= 1'b0;
            r_cfg.default_advance       <= '0;
            r_cfg.glyph_count           <= '0;
            r_cfg.scale_factor          <= RST_SCALE;
            r_cfg.headerless_wide       <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_SPACING:  r_cfg.spacing               <= pwdata[15:0];
                REG_FALLBACK: r_cfg.fallback_advance      <= pwdata[15:0];
                REG_EXTRA:    r_cfg.extra_unknown_advance <= pwdata[15:0];
                REG_SIMPLE:   r_cfg.simple_mode           <= pwdata[0];
                REG_DEFADV:   r_cfg.default_advance       <= pwdata[7:0];
                REG_GCOUNT:   r_cfg.glyph_count           <= pwdata[8:0];
                REG_SCALE:    r_cfg.scale_factor          <= pwdata[15:0];
                REG_HLWIDE:   r_cfg.headerless_wide       <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SPACING:  prdata = CFG_DW'(r_cfg.spacing);
            REG_FALLBACK: prdata = CFG_DW'(r_cfg.fallback_advance);
            REG_EXTRA:    prdata = CFG_DW'(r_cfg.extra_unknown_advance);
            REG_SIMPLE:   prdata = CFG_DW'(r_cfg.simple_mode);
            REG_DEFADV:   prdata = CFG_DW'(r_cfg.default_advance);
            REG_GCOUNT:   prdata = CFG_DW'(r_cfg.glyph_count);
            REG_SCALE:    prdata = CFG_DW'(r_cfg.scale_factor);
            REG_HLWIDE:   prdata = CFG_DW'(r_cfg.headerless_wide);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer registers.
    // ------------------------------------------------------------------
    logic [2:0]       r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic             r_wide,  n_wide;
    logic [7:0]       r_held,  n_held;
    // Character under measurement (low byte and high-byte-is-zero flag),
    // an optional second narrow character, and a pending terminator.
    logic [7:0]       r_ch0,   n_ch0;
    logic             r_hz0,   n_hz0;
    logic [7:0]       r_ch1,   n_ch1;
    logic             r_m1,    n_m1;
    logic             r_fin,   n_fin;
    // Scan state: next entry to read, a read in flight, match result.
    logic [LIM_W-1:0] r_idx,   n_idx;
    logic             r_pend,  n_pend;
    logic             r_found, n_found;

    // Result register; the sequencer can work on the next string while an
    // earlier result waits here for the sink.
    logic             r_ovalid;
    logic [23:0]      r_o_raw;
    logic [31:0]      r_o_scaled;
    logic [15:0]      r_o_count;
    logic             r_o_wide;
    logic             r_o_sat;

    logic             w_accept;
    logic             w_out_free;
    logic             w_skip;
    logic [LIM_W-1:0] w_entries;
    logic [LIM_W-1:0] w_gcount;
    logic [LIM_W-1:0] w_limit;
    logic             w_hit;
    logic             w_issue;
    logic             w_we;
    logic [15:0]      w_windex;
    t_glyph           w_wdata;
    t_glyph           w_rdata;
    t_dp_ctrl         w_ctrl;

    logic [SUM_BITS-1:0] w_dp_sum;
    logic [15:0]         w_dp_count;
    logic                w_dp_clip;
    logic [31:0]         w_dp_scaled;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;

    // ------------------------------------------------------------------
    // Glyph table. Loads outside the configured depth are dropped.
    // ------------------------------------------------------------------
    assign w_windex = 16'(i_in.entry_index);
    assign w_we     = w_accept && (i_in.cmd == CMD_LOAD)
                   && ({8'd0, w_windex} < 24'(GLYPH_ENTRIES));
    assign w_wdata  = '{code: i_in.entry_code, width: i_in.entry_width,
                        kerning: i_in.entry_kerning};

    // A space, or a wide character with a nonzero high byte, never matches:
    // the scan limit drops to zero and the character counts as unknown.
    assign w_skip    = !r_hz0 || (r_ch0 == CODE_SPACE);
    assign w_entries = LIM_W'(GLYPH_ENTRIES);
    assign w_gcount  = LIM_W'(r_cfg.glyph_count);
    assign w_limit   = w_skip ? '0 : ((w_gcount < w_entries) ? w_gcount : w_entries);

    // The memory returns an entry in the cycle after its address is issued, so
    // the compare checks the previous entry while the next one is read.
    assign w_hit   = r_pend && (w_rdata.code == r_ch0);
    assign w_issue = (r_idx < w_limit) && !w_hit;

    trwm_glyph_mem #(
        .ENTRIES (GLYPH_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_windex[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_re    ((r_state == S_SEARCH) && w_issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    trwm_datapath #(
        .SUM_BITS (SUM_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cfg    (r_cfg),
        .i_found  (r_found),
        .i_glyph  (w_rdata),
        .o_sum    (w_dp_sum),
        .o_count  (w_dp_count),
        .o_clip   (w_dp_clip),
        .o_scaled (w_dp_scaled)
    );

    // ------------------------------------------------------------------
    // Sequencer. An accepted text byte is decoded against the string phase
    // into zero, one or two characters to measure and possibly a terminator;
    // each character is then scanned, its increment formed and accumulated.
    // ------------------------------------------------------------------
    always_comb begin
        logic       v_meas;
        logic [7:0] v_b;

        v_meas  = 1'b0;
        v_b     = i_in.text_byte;
        n_state = r_state;
        n_phase = r_phase;
        n_wide  = r_wide;
        n_held  = r_held;
        n_ch0   = r_ch0;
        n_hz0   = r_hz0;
        n_ch1   = r_ch1;
        n_m1    = r_m1;
        n_fin   = r_fin;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_found = r_found;
        w_ctrl  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in.cmd == CMD_TEXT)) begin
                    n_m1  = 1'b0;
                    n_fin = 1'b0;
                    unique case (r_phase)
                        PH_START: begin
                            if (r_cfg.headerless_wide) begin
                                n_wide  = 1'b1;
                                n_held  = v_b;
                                n_phase = PH_PAIR;
                            end else if (v_b == BOM_FIRST) begin
                                n_held  = v_b;
                                n_phase = PH_MARK;
                            end else if (v_b == CODE_NUL) begin
                                n_fin = 1'b1;
                            end else begin
                                v_meas  = 1'b1;
                                n_ch0   = v_b;
                                n_hz0   = 1'b1;
                                n_phase = PH_WALK;
                            end
                        end
                        PH_MARK: begin
                            n_held  = CODE_NUL;
                            n_phase = PH_WALK;
                            if (v_b == BOM_SECOND) begin
                                n_wide = 1'b1;
                            end else begin
                                // A lone leading 0xFF is an ordinary narrow
                                // character, followed by this byte.
                                v_meas = 1'b1;
                                n_ch0  = r_held;
                                n_hz0  = 1'b1;
                                if (v_b == CODE_NUL) begin
                                    n_fin = 1'b1;
                                end else begin
                                    n_ch1 = v_b;
                                    n_m1  = 1'b1;
                                end
                            end
                        end
                        PH_WALK: begin
                            if (r_wide) begin
                                n_held  = v_b;
                                n_phase = PH_PAIR;
                            end else if (v_b == CODE_NUL) begin
                                n_fin = 1'b1;
                            end else begin
                                v_meas = 1'b1;
                                n_ch0  = v_b;
                                n_hz0  = 1'b1;
                            end
                        end
                        PH_PAIR: begin
                            // Only an all-zero pair ends a wide string.
                            if ((r_held == CODE_NUL) && (v_b == CODE_NUL)) begin
                                n_fin = 1'b1;
                            end else begin
                                v_meas  = 1'b1;
                                n_ch0   = r_held;
                                n_hz0   = (v_b == CODE_NUL);
                                n_held  = CODE_NUL;
                                n_phase = PH_WALK;
                            end
                        end
                        default: ;
                    endcase
                    if (v_meas) begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SEARCH;
                    end else if (n_fin) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_SEARCH: begin
                n_pend = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + LIM_W'(1);
                end
                if (w_hit) begin
                    n_found = 1'b1;
                    n_state = S_INC;
                end else if (!w_issue) begin
                    n_found = 1'b0;
                    n_state = S_INC;
                end
            end
            S_INC: begin
                w_ctrl.calc_inc = 1'b1;
                n_state         = S_ACC;
            end
            S_ACC: begin
                w_ctrl.accum = 1'b1;
                if (r_m1) begin
                    n_ch0   = r_ch1;
                    n_hz0   = 1'b1;
                    n_m1    = 1'b0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SEARCH;
                end else if (r_fin) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                w_ctrl.mult = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    w_ctrl.clear = 1'b1;
                    n_phase      = PH_START;
                    n_wide       = 1'b0;
                    n_held       = CODE_NUL;
                    n_fin        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_START;
            r_wide  <= 1'b0;
            r_held  <= CODE_NUL;
            r_m1    <= 1'b0;
            r_fin   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_wide  <= n_wide;
            r_held  <= n_held;
            r_m1    <= n_m1;
            r_fin   <= n_fin;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch0   <= n_ch0;
        r_hz0   <= n_hz0;
        r_ch1   <= n_ch1;
        r_idx   <= n_idx;
        r_found <= n_found;
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_o_raw    <= 24'($signed(w_dp_sum));
            r_o_scaled <= w_dp_scaled;
            r_o_count  <= w_dp_count;
            r_o_wide   <= r_wide;
            r_o_sat    <= w_dp_clip;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.raw_total     = r_o_raw;
    assign o_out.scaled_width  = r_o_scaled;
    assign o_out.char_count    = r_o_count;
    assign o_out.wide_detected = r_o_wide;
    assign o_out.saturated     = r_o_sat;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A table load never starts the sequencer.
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.cmd == CMD_LOAD)) |=> i_in.ready)
        else $error("table load did not return to ready");

    // The scan counter never runs past the table depth.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx <= w_entries))
        else $error("glyph scan ran past the table");

    // Handing off a result leaves a clean string state behind.
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && w_out_free) |=>
            ((w_dp_count == 16'd0) && (r_phase == PH_START) && !r_wide && o_out.valid))
        else $error("string state not cleared after result");

    // The product step always leads straight to the result step.
    a_mul_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_OUT))
        else $error("multiply step not followed by result step");

endmodule
